>>> rtl/core/mbrtu_pkg.sv
// Package with shared types, constants and helpers for the Modbus RTU holding-register slave.
`default_nettype none
package mbrtu_pkg;
  localparam int unsigned HoldingRegCount = 64;
  localparam int unsigned MaxReadWords = 29;
  localparam logic [7:0] StationReset = 8'd1;
  localparam logic [7:0] FuncRead = 8'h03;
  localparam logic [7:0] FuncWrite = 8'h06;
  localparam logic [8:0] RequestLen = 9'd8;
  localparam logic [8:0] FrameLenMax = 9'd511;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_frame;
  } rx_req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } tx_req_t;

  typedef struct packed {
    logic        is_write;
    logic [7:0]  addr;
    logic [7:0]  func;
    logic [15:0] start;
    logic [15:0] count;
  } cmd_t;

  function automatic logic [15:0] crc_bit(input logic [15:0] crc);
    crc_bit = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
  endfunction

  function automatic logic [15:0] reg_reset(input int unsigned idx);
    case (idx)
      0: reg_reset = 16'd1;
      1: reg_reset = 16'd3;
      3: reg_reset = 16'd10;
      4: reg_reset = 16'd1000;
      default: reg_reset = 16'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/mbrtu_front.sv
// Front end: collects frame bytes, runs the bit-serial CRC and classifies good requests.
`default_nettype none
module mbrtu_front #(
  parameter int unsigned HOLDING_REG_COUNT = mbrtu_pkg::HoldingRegCount,
  parameter int unsigned MAX_READ_WORDS = mbrtu_pkg::MaxReadWords
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [7:0]        station_i,
  input  wire logic              push,
  output logic                   full,
  input  wire mbrtu_pkg::rx_req_t rx_i,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_ready_i,
  output mbrtu_pkg::cmd_t        cmd_o
);
  logic [7:0]  hdr_q [6];
  logic [8:0]  len_q;
  logic [15:0] crc_q;
  logic [2:0]  bit_q;
  logic        busy_q, eof_q;
  logic        cmd_valid_q;
  mbrtu_pkg::cmd_t cmd_q;

  logic [15:0] start_w, count_w;
  logic [16:0] end_w;
  logic        good_w, wr_ok, rd_ok;

  assign full = busy_q || cmd_valid_q;
  assign cmd_valid_o = cmd_valid_q;
  assign cmd_o = cmd_q;

  assign start_w = {hdr_q[2], hdr_q[3]};
  assign count_w = {hdr_q[4], hdr_q[5]};
  assign end_w = {1'b0, start_w} + {1'b0, count_w};
  assign good_w = (len_q == mbrtu_pkg::RequestLen) && (mbrtu_pkg::crc_bit(crc_q) == 16'd0)
                  && (hdr_q[0] == station_i);
  assign wr_ok = (hdr_q[1] == mbrtu_pkg::FuncWrite) && (start_w < 16'(HOLDING_REG_COUNT));
  assign rd_ok = (hdr_q[1] == mbrtu_pkg::FuncRead) && (count_w <= 16'(MAX_READ_WORDS))
                 && (end_w <= 17'(HOLDING_REG_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) hdr_q[i] <= 8'd0;
      len_q <= 9'd0;
      crc_q <= mbrtu_pkg::CrcInit;
      bit_q <= 3'd0;
      busy_q <= 1'b0;
      eof_q <= 1'b0;
      cmd_valid_q <= 1'b0;
      cmd_q <= '0;
    end else begin
      if (cmd_valid_q && cmd_ready_i) cmd_valid_q <= 1'b0;
      if (push && !full) begin
        if (len_q < 9'd6) hdr_q[len_q[2:0]] <= rx_i.rx_byte;
        if (len_q < mbrtu_pkg::FrameLenMax) len_q <= len_q + 9'd1;
        crc_q <= crc_q ^ {8'd0, rx_i.rx_byte};
        bit_q <= 3'd0;
        busy_q <= 1'b1;
        eof_q <= rx_i.end_of_frame;
      end else if (busy_q) begin
        bit_q <= bit_q + 3'd1;
        if (bit_q == 3'd7) begin
          busy_q <= 1'b0;
          if (eof_q) begin
            if (good_w && (wr_ok || rd_ok)) begin
              cmd_valid_q <= 1'b1;
              cmd_q <= '{is_write: wr_ok, addr: hdr_q[0], func: hdr_q[1],
                         start: start_w, count: count_w};
            end
            for (int i = 0; i < 6; i++) hdr_q[i] <= 8'd0;
            len_q <= 9'd0;
            crc_q <= mbrtu_pkg::CrcInit;
          end else begin
            crc_q <= mbrtu_pkg::crc_bit(crc_q);
          end
        end else begin
          crc_q <= mbrtu_pkg::crc_bit(crc_q);
        end
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_q && !cmd_ready_i) |=> cmd_valid_q && $stable(cmd_q))
    else $error("command changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> busy_q)
    else $error("accepted byte not in progress");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cmd_valid_q) |-> $past(busy_q) && $past(bit_q) == 3'd7)
    else $error("command without finished byte");
endmodule
`default_nettype wire

>>> rtl/core/mbrtu_back.sv
// Back end: holds the register file, executes commands and streams response bytes.
`default_nettype none
module mbrtu_back #(
  parameter int unsigned HOLDING_REG_COUNT = mbrtu_pkg::HoldingRegCount
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  output logic                 cmd_ready_o,
  input  wire mbrtu_pkg::cmd_t cmd_i,
  output logic                 empty,
  input  wire logic            pop,
  output mbrtu_pkg::tx_req_t   tx_o
);
  localparam int unsigned AW = $clog2(HOLDING_REG_COUNT);

  typedef enum logic [2:0] {
    StIdle, StHead, StWordHi, StWordLo, StCrcLo, StCrcHi
  } state_e;

  state_e          state_q;
  mbrtu_pkg::cmd_t cmd_q;
  logic [15:0]     regs_q [HOLDING_REG_COUNT];
  logic [2:0]      idx_q;
  logic [15:0]     left_q;
  logic [AW-1:0]   ptr_q;
  logic [15:0]     crc_q;
  logic [15:0]     word_q;
  logic [3:0]      cbit_q;
  logic            crc_busy_q;
  logic            out_valid_q;
  mbrtu_pkg::tx_req_t out_q;
  logic [AW-1:0]   init_q;
  logic            init_busy_q;
  logic [7:0]      byte_w;
  logic            can_emit;
  logic            emit_w;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [15:0]     mem_wdata;

  assign empty = !out_valid_q;
  assign tx_o = out_q;
  assign cmd_ready_o = (state_q == StIdle) && !init_busy_q;
  assign can_emit = (!out_valid_q || pop) && !crc_busy_q;
  assign emit_w = can_emit && (state_q != StIdle);

  assign mem_we = init_busy_q || (cmd_valid_i && cmd_ready_o && cmd_i.is_write);
  assign mem_waddr = init_busy_q ? init_q : cmd_i.start[AW-1:0];
  assign mem_wdata = init_busy_q ? mbrtu_pkg::reg_reset(32'(init_q)) : cmd_i.count;
  assign mem_re = can_emit && (((state_q == StHead) && !cmd_q.is_write && (idx_q == 3'd2)
                                && (left_q != 16'd0))
                               || ((state_q == StWordLo) && (left_q != 16'd1)));
  assign mem_raddr = (state_q == StWordLo) ? ptr_q + AW'(1) : ptr_q;

  always_comb begin
    byte_w = 8'd0;
    if (cmd_q.is_write) begin
      case (idx_q)
        3'd0: byte_w = cmd_q.addr;
        3'd1: byte_w = cmd_q.func;
        3'd2: byte_w = cmd_q.start[15:8];
        3'd3: byte_w = cmd_q.start[7:0];
        3'd4: byte_w = cmd_q.count[15:8];
        default: byte_w = cmd_q.count[7:0];
      endcase
    end else begin
      case (idx_q)
        3'd0: byte_w = cmd_q.addr;
        3'd1: byte_w = cmd_q.func;
        default: byte_w = {cmd_q.count[6:0], 1'b0};
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) regs_q[mem_waddr] <= mem_wdata;
    if (mem_re) word_q <= regs_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
      out_q <= '0;
      crc_busy_q <= 1'b0;
      cbit_q <= 4'd0;
      crc_q <= mbrtu_pkg::CrcInit;
      cmd_q <= '0;
      idx_q <= 3'd0;
      left_q <= 16'd0;
      ptr_q <= '0;
      init_q <= '0;
      init_busy_q <= 1'b1;
    end else begin
      if (init_busy_q) begin
        init_q <= init_q + AW'(1);
        if (init_q == AW'(HOLDING_REG_COUNT - 1)) init_busy_q <= 1'b0;
      end
      if (out_valid_q && pop && !emit_w) out_valid_q <= 1'b0;
      if (crc_busy_q) begin
        crc_q <= mbrtu_pkg::crc_bit(crc_q);
        cbit_q <= cbit_q + 4'd1;
        if (cbit_q == 4'd7) crc_busy_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (cmd_valid_i && !init_busy_q) begin
            cmd_q <= cmd_i;
            idx_q <= 3'd0;
            left_q <= cmd_i.count;
            ptr_q <= cmd_i.start[AW-1:0];
            crc_q <= mbrtu_pkg::CrcInit;
            state_q <= StHead;
          end
        end
        StHead: begin
          if (can_emit) begin
            out_valid_q <= 1'b1;
            out_q <= '{tx_byte: byte_w, last_byte: 1'b0};
            crc_q <= crc_q ^ {8'd0, byte_w};
            crc_busy_q <= 1'b1;
            cbit_q <= 4'd0;
            idx_q <= idx_q + 3'd1;
            if ((cmd_q.is_write && idx_q == 3'd5) || (!cmd_q.is_write && idx_q == 3'd2)) begin
              if (cmd_q.is_write || left_q == 16'd0) state_q <= StCrcLo;
              else state_q <= StWordHi;
            end
          end
        end
        StWordHi: begin
          if (can_emit) begin
            out_valid_q <= 1'b1;
            out_q <= '{tx_byte: word_q[15:8], last_byte: 1'b0};
            crc_q <= crc_q ^ {8'd0, word_q[15:8]};
            crc_busy_q <= 1'b1;
            cbit_q <= 4'd0;
            state_q <= StWordLo;
          end
        end
        StWordLo: begin
          if (can_emit) begin
            out_valid_q <= 1'b1;
            out_q <= '{tx_byte: word_q[7:0], last_byte: 1'b0};
            crc_q <= crc_q ^ {8'd0, word_q[7:0]};
            crc_busy_q <= 1'b1;
            cbit_q <= 4'd0;
            left_q <= left_q - 16'd1;
            ptr_q <= ptr_q + AW'(1);
            if (left_q == 16'd1) state_q <= StCrcLo;
            else state_q <= StWordHi;
          end
        end
        StCrcLo: begin
          if (can_emit) begin
            out_valid_q <= 1'b1;
            out_q <= '{tx_byte: crc_q[7:0], last_byte: 1'b0};
            state_q <= StCrcHi;
          end
        end
        StCrcHi: begin
          if (can_emit) begin
            out_valid_q <= 1'b1;
            out_q <= '{tx_byte: crc_q[15:8], last_byte: 1'b1};
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop) |=> out_valid_q && $stable(out_q))
    else $error("response byte lost while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCrcHi && can_emit) |=> out_q.last_byte && state_q == StIdle)
    else $error("final byte not marked");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_busy_q |-> state_q != StIdle)
    else $error("crc running while idle");
endmodule
`default_nettype wire

>>> rtl/core/modbus_rtu_holding_register_slave.sv
// Top level of the Modbus RTU holding-register slave for function codes 03 and 06.
//   channel   direction  handshake          payload
//   request   in         push / full        rx_i (rx_byte, end_of_frame)
//   response  out        empty / pop        tx_o (tx_byte, last_byte)
//   config    in         cfg_valid/ready    cfg_data_i (station_address)
// Each received byte is loaded, then run through the bit-serial CRC while full stays high.
// Each response byte before the CRC is paced by the bit-serial response CRC; the two CRC
// bytes then follow one per cycle while the consumer keeps popping.
// Reset restores the station address at once; the register file then reloads its reset
// values in a pass over every register, and commands wait until that pass ends.
// A stalled response holds the back end; the front end holds full while its command waits.
`default_nettype none
module modbus_rtu_holding_register_slave #(
  parameter int unsigned HOLDING_REG_COUNT = mbrtu_pkg::HoldingRegCount,
  parameter int unsigned MAX_READ_WORDS = mbrtu_pkg::MaxReadWords
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire mbrtu_pkg::rx_req_t rx_i,
  output logic                    empty,
  input  wire logic               pop,
  output mbrtu_pkg::tx_req_t      tx_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [7:0]         cfg_data_i
);
  logic [7:0]      station_q;
  logic            cmd_valid, cmd_ready;
  mbrtu_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) station_q <= mbrtu_pkg::StationReset;
    else if (cfg_valid_i && cfg_ready_o) station_q <= cfg_data_i;
  end

  mbrtu_front #(.HOLDING_REG_COUNT(HOLDING_REG_COUNT), .MAX_READ_WORDS(MAX_READ_WORDS)) u_front (
    .clk_i, .rst_ni, .station_i(station_q), .push, .full, .rx_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  mbrtu_back #(.HOLDING_REG_COUNT(HOLDING_REG_COUNT)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .empty, .pop, .tx_o
  );
endmodule
`default_nettype wire
